/* design/lcd4ws_pkg.sv */
// Types, constants and lookup functions shared by the LCD write sequencer.
`timescale 1ns / 1ps
package lcd4ws_pkg;

  localparam int DATA_PINS  = 4;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int HOLD_W     = 17;
  localparam int INIT_LEN   = 6;
  localparam int INIT_IDX_W = 3;

  localparam logic [7:0] HI_MASK   = 8'hf0;
  localparam logic [7:0] LO_MASK   = 8'h0f;
  localparam logic [7:0] CMD_CLEAR = 8'h01;

  localparam logic [CFG_IDX_W-1:0] CFG_PULSE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_CLEAR  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_GOTO   = CFG_IDX_W'(3);

  localparam logic [CFG_W-1:0] PULSE_RST  = 16'd16;
  localparam logic [CFG_W-1:0] SETTLE_RST = 16'd1600;
  localparam logic [CFG_W-1:0] CLEAR_RST  = 16'd32000;
  localparam logic [CFG_W-1:0] GOTO_RST   = 16'd1600;

  typedef enum logic [1:0] {
    OP_CMD  = 2'd0,
    OP_DATA = 2'd1,
    OP_GOTO = 2'd2,
    OP_INIT = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    EXTRA_NONE,
    EXTRA_CLEAR,
    EXTRA_GOTO
  } extra_e;

  typedef enum logic {
    FS_IDLE,
    FS_INIT
  } front_state_e;

  // One byte word queued between the front and the back
  typedef struct packed {
    logic [7:0] value;
    logic       rs;
    extra_e     extra;
    logic       last;
  } byte_word_t;

  typedef struct packed {
    logic [CFG_W-1:0] pulse;
    logic [CFG_W-1:0] settle;
    logic [CFG_W-1:0] clear_wait;
    logic [CFG_W-1:0] goto_wait;
  } cfg_t;

  function automatic logic [7:0] row_base(input logic [1:0] sel);
    logic [7:0] b;
    case (sel)
      2'd0:    b = 8'h80;
      2'd1:    b = 8'hc0;
      2'd2:    b = 8'h94;
      default: b = 8'hd4;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] init_seq(input logic [INIT_IDX_W-1:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h33;
      3'd1:    c = 8'h32;
      3'd2:    c = 8'h28;
      3'd3:    c = 8'h0c;
      3'd4:    c = 8'h01;
      default: c = 8'h06;
    endcase
    return c;
  endfunction

endpackage

/* design/lcd4ws_if.sv */
// Handshake interfaces for the operation, pin-state and configuration channels.
`timescale 1ns / 1ps
interface lcd4ws_op_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] byte_value;
  logic [2:0] row;
  logic [4:0] column;
  modport source (output valid, opcode, byte_value, row, column, input ready);
  modport sink   (input valid, opcode, byte_value, row, column, output ready);
endinterface

interface lcd4ws_pin_if;
  logic        valid;
  logic        ready;
  logic [3:0]  bus_nibble;
  logic        reg_select;
  logic        enable_line;
  logic [16:0] hold_cycles;
  logic        last;
  modport source (output valid, bus_nibble, reg_select, enable_line, hold_cycles, last,
                  input ready);
  modport sink   (input valid, bus_nibble, reg_select, enable_line, hold_cycles, last,
                  output ready);
endinterface

interface lcd4ws_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* design/char_lcd_4bit_write_sequencer.sv */
// Top level of the 4-bit character LCD write sequencer.
`timescale 1ns / 1ps
// Each operation word on op_i becomes a run of pin-state words on pin_o, each
// naming the nibble, register select, enable level and how many cycles to hold
// it; the final word of an operation carries last. Command, data and cursor
// move operations give four pin states each, initialisation twenty-four; the
// back end sends one pin state per cycle while the sink is ready and a byte
// word is queued. A short queue between the front end, which expands operations
// into byte words, and the back end lets the next operation be taken once the
// previous one's byte words are queued, while that one is still being sent and
// while a pin state waits on a stalled sink. Timing registers are written on
// cfg_i (always ready) and must only change while no operation is outstanding.
module char_lcd_4bit_write_sequencer #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  lcd4ws_cfg_if.sink    cfg_i,
  lcd4ws_op_if.sink     op_i,
  lcd4ws_pin_if.source  pin_o
);
  import lcd4ws_pkg::*;

  cfg_t        cfg_q, cfg_d;
  logic        push;
  logic        full;
  logic        pop;
  logic        q_valid;
  byte_word_t  push_word;
  byte_word_t  q_word;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_PULSE:  cfg_d.pulse      = cfg_i.data;
        CFG_SETTLE: cfg_d.settle     = cfg_i.data;
        CFG_CLEAR:  cfg_d.clear_wait = cfg_i.data;
        CFG_GOTO:   cfg_d.goto_wait  = cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulse      <= PULSE_RST;
      cfg_q.settle     <= SETTLE_RST;
      cfg_q.clear_wait <= CLEAR_RST;
      cfg_q.goto_wait  <= GOTO_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  lcd4ws_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (op_i),
    .full_i (full),
    .push_o (push),
    .word_o (push_word)
  );

  lcd4ws_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .word_i  (push_word),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .word_o  (q_word)
  );

  lcd4ws_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_word_i  (q_word),
    .pop_o     (pop),
    .pin_o     (pin_o)
  );

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && full))
    else $error("byte word pushed into a full queue");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_valid)
    else $error("byte word popped from an empty queue");

  a_accept_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i.valid && op_i.ready) |-> (push && !full))
    else $error("operation accepted without a queue slot");

  a_last_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pin_o.valid && pin_o.last) |-> !pin_o.enable_line)
    else $error("final pin state with enable high");

endmodule

/* design/lcd4ws_front.sv */
// Front end: accepts operations and expands them into byte words.
`timescale 1ns / 1ps
module lcd4ws_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  lcd4ws_op_if.sink               op_i,
  input  logic                    full_i,
  output logic                    push_o,
  output lcd4ws_pkg::byte_word_t  word_o
);
  import lcd4ws_pkg::*;

  front_state_e            state_q, state_d;
  logic [INIT_IDX_W-1:0]   idx_q, idx_d;
  logic                    accept;
  logic                    init_last;
  logic [7:0]              goto_addr;

  assign accept    = op_i.valid && op_i.ready;
  assign init_last = (idx_q == INIT_IDX_W'(INIT_LEN - 1));
  assign goto_addr = row_base(op_i.row[1:0] - 2'd1) + {3'b000, op_i.column} - 8'd1;

  // Next state
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      FS_IDLE: begin
        if (accept && opcode_e'(op_i.opcode) == OP_INIT) begin
          state_d = FS_INIT;
          idx_d   = INIT_IDX_W'(1);
        end
      end
      FS_INIT: begin
        if (!full_i) begin
          idx_d = idx_q + INIT_IDX_W'(1);
          if (init_last) begin
            state_d = FS_IDLE;
          end
        end
      end
      default: state_d = FS_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    op_i.ready   = 1'b0;
    push_o       = 1'b0;
    word_o.value = 8'h00;
    word_o.rs    = 1'b0;
    word_o.extra = EXTRA_NONE;
    word_o.last  = 1'b0;
    unique case (state_q)
      FS_IDLE: begin
        op_i.ready = !full_i;
        push_o     = op_i.valid && !full_i;
        unique case (opcode_e'(op_i.opcode))
          OP_CMD: begin
            word_o.value = op_i.byte_value;
            word_o.last  = 1'b1;
          end
          OP_DATA: begin
            word_o.value = op_i.byte_value;
            word_o.rs    = 1'b1;
            word_o.last  = 1'b1;
          end
          OP_GOTO: begin
            word_o.value = goto_addr;
            word_o.extra = EXTRA_GOTO;
            word_o.last  = 1'b1;
          end
          default: begin
            word_o.value = init_seq(INIT_IDX_W'(0));
          end
        endcase
      end
      FS_INIT: begin
        push_o       = !full_i;
        word_o.value = init_seq(idx_q);
        word_o.extra = (init_seq(idx_q) == CMD_CLEAR) ? EXTRA_CLEAR : EXTRA_NONE;
        word_o.last  = init_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

/* design/lcd4ws_queue.sv */
// Short first-in first-out queue of byte words between front and back.
`timescale 1ns / 1ps
module lcd4ws_queue #(
  parameter int DEPTH = 2
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  lcd4ws_pkg::byte_word_t  word_i,
  output logic                    full_o,
  input  logic                    pop_i,
  output logic                    valid_o,
  output lcd4ws_pkg::byte_word_t  word_o
);
  import lcd4ws_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  byte_word_t         mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign word_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= word_i;
    end
  end

endmodule

/* design/lcd4ws_back.sv */
// Back end: turns each byte word into four timed pin states.
`timescale 1ns / 1ps
module lcd4ws_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lcd4ws_pkg::cfg_t        cfg_i,
  input  logic                    q_valid_i,
  input  lcd4ws_pkg::byte_word_t  q_word_i,
  output logic                    pop_o,
  lcd4ws_pin_if.source            pin_o
);
  import lcd4ws_pkg::*;

  function automatic logic [HOLD_W-1:0] at_least_one(input logic [HOLD_W-1:0] v);
    return (v == '0) ? HOLD_W'(1) : v;
  endfunction

  logic [1:0]           phase_q, phase_d;
  logic                 valid_q, valid_d;
  logic [DATA_PINS-1:0] nib_q, nib_d;
  logic                 rs_q, rs_d;
  logic                 en_q, en_d;
  logic [HOLD_W-1:0]    hold_q, hold_d;
  logic                 last_q, last_d;
  logic                 advance;
  logic [CFG_W-1:0]     extra;
  logic [HOLD_W-1:0]    settle;

  // Take the next slot when a byte word is queued and the output register is free or being drained
  assign advance = q_valid_i && (!valid_q || pin_o.ready);
  assign pop_o   = advance && (phase_q == 2'd3);

  always_comb begin
    case (q_word_i.extra)
      EXTRA_CLEAR: extra = cfg_i.clear_wait;
      EXTRA_GOTO:  extra = cfg_i.goto_wait;
      default:     extra = '0;
    endcase
    settle = {1'b0, cfg_i.settle};
    if (phase_q == 2'd3) begin
      settle = {1'b0, cfg_i.settle} + {1'b0, extra};
    end
  end

  always_comb begin
    phase_d = phase_q;
    valid_d = valid_q && !pin_o.ready;
    nib_d   = nib_q;
    rs_d    = rs_q;
    en_d    = en_q;
    hold_d  = hold_q;
    last_d  = last_q;
    if (advance) begin
      phase_d = phase_q + 2'd1;
      valid_d = 1'b1;
      nib_d   = phase_q[1] ? DATA_PINS'(q_word_i.value & LO_MASK)
                           : DATA_PINS'((q_word_i.value & HI_MASK) >> 4);
      rs_d    = q_word_i.rs;
      en_d    = !phase_q[0];
      hold_d  = phase_q[0] ? at_least_one(settle) : at_least_one({1'b0, cfg_i.pulse});
      last_d  = (phase_q == 2'd3) && q_word_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nib_q  <= nib_d;
    rs_q   <= rs_d;
    en_q   <= en_d;
    hold_q <= hold_d;
    last_q <= last_d;
  end

  assign pin_o.valid       = valid_q;
  assign pin_o.bus_nibble  = nib_q;
  assign pin_o.reg_select  = rs_q;
  assign pin_o.enable_line = en_q;
  assign pin_o.hold_cycles = hold_q;
  assign pin_o.last        = last_q;

endmodule

/* tb/sv/char_lcd_4bit_write_sequencer_tb.sv */
// Self-checking testbench for the 4-bit character LCD write sequencer.
`timescale 1ns / 1ps

import lcd4ws_pkg::*;

typedef struct packed {
  logic [DATA_PINS-1:0] nibble;
  logic                 rs;
  logic                 en;
  logic [HOLD_W-1:0]    hold;
  logic                 last;
} pin_state_t;

typedef struct packed {
  opcode_e    code;
  logic [7:0] value;
  logic [2:0] row;
  logic [4:0] column;
} op_word_t;

// Expands each accepted operation into its pin states and checks the block against them
class lcd_pin_scoreboard;
  logic [CFG_W-1:0] pulse_len;
  logic [CFG_W-1:0] settle_len;
  logic [CFG_W-1:0] clear_wait;
  logic [CFG_W-1:0] goto_wait;
  logic [7:0]       row_addr [4];
  logic [7:0]       init_cmds [INIT_LEN];
  pin_state_t       pin_states_due [$];
  int               mismatches;

  function new();
    pulse_len  = PULSE_RST;
    settle_len = SETTLE_RST;
    clear_wait = CLEAR_RST;
    goto_wait  = GOTO_RST;
    row_addr   = '{8'h80, 8'hc0, 8'h94, 8'hd4};
    init_cmds  = '{8'h33, 8'h32, 8'h28, 8'h0c, 8'h01, 8'h06};
    mismatches = 0;
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    case (idx)
      CFG_PULSE:  pulse_len  = value;
      CFG_SETTLE: settle_len = value;
      CFG_CLEAR:  clear_wait = value;
      CFG_GOTO:   goto_wait  = value;
      default: ;
    endcase
  endfunction

  function int pending();
    return pin_states_due.size();
  endfunction

  // High nibble first; each nibble is a strobe-high then a strobe-low state
  function void push_byte(logic [7:0] value, logic rs, logic [CFG_W-1:0] extra,
                          logic ends_op);
    pin_state_t       st;
    logic [HOLD_W-1:0] settle_hold;
    for (int i = 0; i < 2; i++) begin
      st.nibble = (i == 0) ? value[7:4] : value[3:0];
      st.rs     = rs;
      st.en     = 1'b1;
      st.hold   = (pulse_len == '0) ? HOLD_W'(1) : HOLD_W'(pulse_len);
      st.last   = 1'b0;
      pin_states_due.push_back(st);
      settle_hold = HOLD_W'(settle_len) + ((i == 1) ? HOLD_W'(extra) : '0);
      st.en     = 1'b0;
      st.hold   = (settle_hold == '0) ? HOLD_W'(1) : settle_hold;
      st.last   = ends_op && (i == 1);
      pin_states_due.push_back(st);
    end
  endfunction

  function void note_op(op_word_t w);
    logic [2:0] row_m1;
    logic [7:0] addr;
    case (w.code)
      OP_CMD:  push_byte(w.value, 1'b0, '0, 1'b1);
      OP_DATA: push_byte(w.value, 1'b1, '0, 1'b1);
      OP_GOTO: begin
        // only the low two bits of the zero-based row pick the base
        row_m1 = w.row - 3'd1;
        addr   = row_addr[row_m1[1:0]] + {3'b000, w.column} - 8'd1;
        push_byte(addr, 1'b0, goto_wait, 1'b1);
      end
      default: begin
        for (int i = 0; i < INIT_LEN; i++)
          push_byte(init_cmds[i], 1'b0, (init_cmds[i] == CMD_CLEAR) ? clear_wait : '0,
                    i == INIT_LEN - 1);
      end
    endcase
  endfunction

  function void check_pin(pin_state_t got);
    pin_state_t want;
    if (pin_states_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected pin state %h", $realtime, got);
      return;
    end
    want = pin_states_due.pop_front();
    if (got.nibble !== want.nibble || got.rs !== want.rs || got.en !== want.en ||
        got.hold !== want.hold || got.last !== want.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: pin state mismatch: nibble %h/%h rs %b/%b en %b/%b hold %0d/%0d last %b/%b",
                 $realtime, want.nibble, got.nibble, want.rs, got.rs, want.en, got.en,
                 want.hold, got.hold, want.last, got.last);
    end
  endfunction
endclass

module char_lcd_4bit_write_sequencer_tb;

  localparam int CYCLE_LIMIT = 300000;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   cycle_cnt = 0;
  int   sink_tick = 0;
  int   stall_left = 0;
  int   gap_odds = 3;

  lcd4ws_cfg_if cfg_if ();
  lcd4ws_op_if  op_if ();
  lcd4ws_pin_if pin_if ();

  lcd_pin_scoreboard pin_sb = new();

  char_lcd_4bit_write_sequencer u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .op_i   (op_if),
    .pin_o  (pin_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (pin_if.valid && pin_if.ready)
      pin_sb.check_pin('{pin_if.bus_nibble, pin_if.reg_select, pin_if.enable_line,
                         pin_if.hold_cycles, pin_if.last});
  end

  // Sink stall pattern: free running, random, periodic, then occasional long stalls
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pin_if.ready = 1'b0;
    end else begin
      sink_tick++;
      case ((sink_tick / 150) % 4)
        0: pin_if.ready = 1'b1;
        1: pin_if.ready = ($urandom_range(0, 9) < 7);
        2: pin_if.ready = ((sink_tick % 5) < 2);
        default: begin
          if (stall_left != 0) begin
            stall_left--;
            pin_if.ready = 1'b0;
          end else begin
            pin_if.ready = 1'b1;
            if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(1, 12);
          end
        end
      endcase
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("char_lcd_4bit_write_sequencer test failed");
    $finish;
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    pin_sb.set_reg(idx, value);
    @(negedge clk_i);
  endtask

  task automatic program_regs(logic [CFG_W-1:0] pulse, logic [CFG_W-1:0] settle,
                              logic [CFG_W-1:0] clr, logic [CFG_W-1:0] go);
    write_reg(CFG_PULSE, pulse);
    write_reg(CFG_SETTLE, settle);
    write_reg(CFG_CLEAR, clr);
    write_reg(CFG_GOTO, go);
    cfg_if.valid = 1'b0;
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_op(op_word_t w);
    op_if.valid      = 1'b1;
    op_if.opcode     = w.code;
    op_if.byte_value = w.value;
    op_if.row        = w.row;
    op_if.column     = w.column;
    @(posedge clk_i);
    while (!op_if.ready) @(posedge clk_i);
    pin_sb.note_op(w);
    @(negedge clk_i);
  endtask

  task automatic drain();
    op_if.valid = 1'b0;
    while (pin_sb.pending() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // Mostly in-range cursor targets; now and then the whole field range
  function automatic op_word_t random_op();
    op_word_t w;
    w.code   = opcode_e'($urandom_range(0, 3));
    w.value  = 8'($urandom);
    w.row    = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(1, 4)) : 3'($urandom);
    w.column = ($urandom_range(0, 9) < 8) ? 5'($urandom_range(1, 20)) : 5'($urandom);
    return w;
  endfunction

  task automatic send_bursts(int n);
    int left;
    int burst;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 8);
      for (int b = 0; b < burst && left > 0; b++) begin
        send_op(random_op());
        left--;
        // hold off once mid-phase until the block has emptied
        if (left == n / 2) drain();
      end
      if (gap_odds != 0 && $urandom_range(0, gap_odds) != 0) begin
        op_if.valid = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end
    end
  endtask

  op_word_t directed [$];

  initial begin
    rst_ni           = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = '0;
    cfg_if.data      = '0;
    op_if.valid      = 1'b0;
    op_if.opcode     = '0;
    op_if.byte_value = '0;
    op_if.row        = '0;
    op_if.column     = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    directed = '{
      '{OP_CMD,  8'h00, 3'd0, 5'd0},
      '{OP_CMD,  8'hff, 3'd7, 5'd31},
      '{OP_DATA, 8'h00, 3'd1, 5'd1},
      '{OP_DATA, 8'hff, 3'd4, 5'd20},
      '{OP_DATA, 8'ha5, 3'd2, 5'd3},
      '{OP_CMD,  8'h5a, 3'd3, 5'd9},
      '{OP_GOTO, 8'h00, 3'd1, 5'd1},
      '{OP_GOTO, 8'hff, 3'd2, 5'd20},
      '{OP_GOTO, 8'h3c, 3'd3, 5'd10},
      '{OP_GOTO, 8'hc3, 3'd4, 5'd20},
      '{OP_GOTO, 8'h00, 3'd0, 5'd1},    // row zero wraps to the last row
      '{OP_GOTO, 8'h00, 3'd5, 5'd5},    // row five wraps to the first
      '{OP_GOTO, 8'h00, 3'd7, 5'd31},
      '{OP_GOTO, 8'h00, 3'd4, 5'd31},   // largest address, 0xf2
      '{OP_GOTO, 8'h00, 3'd1, 5'd0},    // column zero
      '{OP_INIT, 8'h00, 3'd0, 5'd0},
      '{OP_CMD,  8'h01, 3'd6, 5'd17},
      '{OP_INIT, 8'hff, 3'd7, 5'd31},
      '{OP_DATA, 8'h7e, 3'd0, 5'd0}
    };
    foreach (directed[i]) send_op(directed[i]);
    drain();

    // zero timings must still give each pin state a nonzero hold
    program_regs(16'd0, 16'd0, 16'd0, 16'd0);
    gap_odds = 0;
    send_bursts(30);
    drain();

    program_regs(16'hffff, 16'hffff, 16'hffff, 16'hffff);
    gap_odds = 3;
    send_bursts(30);
    drain();

    program_regs(16'd1, 16'd1, 16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)));
    send_bursts(35);
    drain();

    program_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    gap_odds = 1;
    send_bursts(35);
    drain();

    repeat (20) @(negedge clk_i);
    if (pin_sb.mismatches == 0 && pin_sb.pending() == 0)
      $display("char_lcd_4bit_write_sequencer test passed");
    else
      $display("char_lcd_4bit_write_sequencer test failed");
    $finish;
  end

endmodule

/* char_lcd_4bit_write_sequencer.f */
design/lcd4ws_pkg.sv
design/lcd4ws_if.sv
design/lcd4ws_front.sv
design/lcd4ws_queue.sv
design/lcd4ws_back.sv
design/char_lcd_4bit_write_sequencer.sv
tb/sv/char_lcd_4bit_write_sequencer_tb.sv
